### sv/pcof_pkg.sv
// Shared types and constants for the ping clock offset filter.
// No dependencies; every other file imports this package.
package pcof_pkg;

    localparam int WIN_SIZE = 16;
    localparam int LAT_W    = 16;
    localparam int OFS_W    = 58;
    localparam int CNT_W    = $clog2(WIN_SIZE + 1);
    localparam int L16_W    = LAT_W + 3;
    localparam int LSUM_W   = L16_W + CNT_W;
    localparam int SQ_W     = 2 * L16_W;
    localparam int VAR_W    = SQ_W + CNT_W;
    localparam int RAD_W    = SQ_W;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int THR_W    = L16_W + 1;
    localparam int OSUM_W   = OFS_W + CNT_W;
    localparam int DIV_W    = OSUM_W - 1 + 3;
    localparam int DSTEP_W  = $clog2(DIV_W + 1);
    localparam int TIME_W   = 64;
    localparam int SPREAD_W = 20;
    localparam int COFS_W   = 63;

    typedef struct packed {
        logic                    vld;
        logic [LAT_W-1:0]        lat;
        logic signed [OFS_W-1:0] ofs;
    } entry_t;

    typedef struct packed {
        logic lt;
        logic le;
    } cmp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INSERT,
        S_SUM,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_VAR,
        S_VAR_GO,
        S_VAR_WAIT,
        S_SQRT_WAIT,
        S_FILT,
        S_OFS_GO,
        S_OFS_WAIT,
        S_DONE
    } state_t;

endpackage

### sv/ping_clock_offset_filter_top.sv
// Ping clock offset filter: window of 16 cells, median, deviation, filtered offset.
// Depends on pcof_pkg, pcof_cell, pcof_div, pcof_sqrt.
//
//   channel | ports                                       | direction
//   input   | s_valid s_ready s_send_time s_server_time   | in
//           | s_receive_time                              |
//   result  | m_valid m_ready m_round_trip m_median_latency| out
//           | m_latency_spread m_clock_offset             |
//
// One ping at a time: each accept runs the insert, three passes around the cell ring,
// up to three runs of the shared bit-serial divider and a square root; the last divide
// is skipped when no sample qualifies. Synchronous active-low reset empties the window
// and clears the offset. A result waits in the output register while the next ping is
// taken; the block stalls at the end only if that register is still full.
module ping_clock_offset_filter_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pcof_pkg::TIME_W-1:0]   s_send_time,
    input  logic [pcof_pkg::TIME_W-1:0]   s_server_time,
    input  logic [pcof_pkg::TIME_W-1:0]   s_receive_time,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pcof_pkg::LAT_W-1:0]    m_round_trip,
    output logic [pcof_pkg::LAT_W-1:0]    m_median_latency,
    output logic [pcof_pkg::SPREAD_W-1:0] m_latency_spread,
    output logic signed [pcof_pkg::COFS_W-1:0] m_clock_offset
);
    import pcof_pkg::*;

    localparam logic signed [59:0] OFS_HI = (60'sd1 <<< (OFS_W - 1)) - 60'sd1;
    localparam logic signed [59:0] OFS_LO = -(60'sd1 <<< (OFS_W - 1));
    localparam logic [TIME_W-1:0]  DIFF_LIM = 64'd1 << 56;

    state_t state_reg, state_next;

    logic [TIME_W-1:0] send_reg, server_reg, recv_reg;
    logic [CNT_W-1:0]  len_reg, step_reg;
    logic [LSUM_W-1:0] lsum_reg;
    logic [LAT_W-1:0]  median_reg;
    logic              med_found_reg;
    logic [L16_W-1:0]  mean_reg;
    logic [SQ_W-1:0]   prod_reg;
    logic              prod_vld_reg;
    logic [VAR_W-1:0]  var_reg;
    logic [ROOT_W-1:0] spread_reg;
    logic [THR_W-1:0]  thr_reg;
    logic signed [OSUM_W-1:0] osum_reg;
    logic [CNT_W-1:0]  qcnt_reg;
    logic              neg_reg;
    logic signed [TIME_W-1:0] cur_ofs_reg;
    logic              m_valid_reg;
    logic [LAT_W-1:0]  m_rt_reg, m_med_reg;
    logic [SPREAD_W-1:0] m_spr_reg;
    logic [COFS_W-1:0] m_ofs_reg;

    // control
    logic              rotate, insert, div_start, sqrt_start, out_load;
    logic [DIV_W-1:0]  div_dividend, div_quo;
    logic [CNT_W-1:0]  div_divisor;
    logic              div_busy, sqrt_busy;
    logic [ROOT_W-1:0] sqrt_root;

    // cell ring
    entry_t chain [WIN_SIZE];
    cmp_t   flags [WIN_SIZE];
    entry_t new_ent, tail;
    logic [L16_W-1:0] tail_l16, dabs;
    logic [CNT_W-1:0] lt_cnt, le_cnt;

    // new sample
    logic [LAT_W-1:0]  ping;
    logic              srv_ge;
    logic [TIME_W-1:0] mag;
    logic [56:0]       magc;
    logic signed [59:0] twod, ofs_w;
    logic signed [OFS_W-1:0] ofs_c;
    logic [OSUM_W-1:0] osum_mag;

    assign ping   = recv_reg[LAT_W-1:0] - send_reg[LAT_W-1:0];
    assign srv_ge = server_reg >= recv_reg;
    assign mag    = srv_ge ? server_reg - recv_reg : recv_reg - server_reg;
    assign magc   = (mag > DIFF_LIM) ? DIFF_LIM[56:0] : mag[56:0];
    assign twod   = signed'({2'b00, magc, 1'b0});
    assign ofs_w  = (srv_ge ? twod : -twod) + signed'({44'd0, ping});

    always_comb begin
        if (ofs_w > OFS_HI) begin
            ofs_c = OFS_HI[OFS_W-1:0];
        end else if (ofs_w < OFS_LO) begin
            ofs_c = OFS_LO[OFS_W-1:0];
        end else begin
            ofs_c = ofs_w[OFS_W-1:0];
        end
    end

    assign new_ent.vld = 1'b1;
    assign new_ent.lat = ping;
    assign new_ent.ofs = ofs_c;

    assign tail     = chain[WIN_SIZE-1];
    assign tail_l16 = {tail.lat, 3'b000};
    assign dabs     = (tail_l16 >= mean_reg) ? tail_l16 - mean_reg : mean_reg - tail_l16;

    genvar gi;
    generate
        for (gi = 0; gi < WIN_SIZE; gi++) begin : g_cell
            pcof_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (insert || rotate),
                .ent_in   ((gi == 0) ? (insert ? new_ent : chain[WIN_SIZE-1])
                                     : chain[(gi == 0) ? 0 : gi-1]),
                .key      (tail.lat),
                .ent_out  (chain[gi]),
                .flags    (flags[gi])
            );
        end
    endgenerate

    always_comb begin
        lt_cnt = '0;
        le_cnt = '0;
        for (int i = 0; i < WIN_SIZE; i++) begin
            lt_cnt = lt_cnt + CNT_W'(flags[i].lt);
            le_cnt = le_cnt + CNT_W'(flags[i].le);
        end
    end

    assign osum_mag = osum_reg[OSUM_W-1] ? OSUM_W'(-osum_reg) : OSUM_W'(osum_reg);

    pcof_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    pcof_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_quo[RAD_W-1:0]),
        .busy     (sqrt_busy),
        .root     (sqrt_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        rotate       = 1'b0;
        insert       = 1'b0;
        div_start    = 1'b0;
        sqrt_start   = 1'b0;
        out_load     = 1'b0;
        div_dividend = '0;
        div_divisor  = len_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT: begin
                insert     = 1'b1;
                state_next = S_SUM;
            end
            S_SUM: begin
                rotate = 1'b1;
                if (step_reg == CNT_W'(WIN_SIZE - 1)) begin
                    state_next = S_MEAN_GO;
                end
            end
            S_MEAN_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(lsum_reg);
                state_next   = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (!div_busy) begin
                    state_next = S_VAR;
                end
            end
            S_VAR: begin
                rotate = (step_reg != CNT_W'(WIN_SIZE));
                if (step_reg == CNT_W'(WIN_SIZE)) begin
                    state_next = S_VAR_GO;
                end
            end
            S_VAR_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(var_reg);
                state_next   = S_VAR_WAIT;
            end
            S_VAR_WAIT: begin
                if (!div_busy) begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT_WAIT;
                end
            end
            S_SQRT_WAIT: begin
                if (!sqrt_busy) begin
                    state_next = S_FILT;
                end
            end
            S_FILT: begin
                rotate = 1'b1;
                if (step_reg == CNT_W'(WIN_SIZE - 1)) begin
                    state_next = S_OFS_GO;
                end
            end
            S_OFS_GO: begin
                if (qcnt_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = {osum_mag[OSUM_W-2:0], 3'b000};
                    div_divisor  = qcnt_reg;
                    state_next   = S_OFS_WAIT;
                end
            end
            S_OFS_WAIT: begin
                if (!div_busy) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            cur_ofs_reg   <= '0;
            m_valid_reg   <= 1'b0;
            med_found_reg <= 1'b0;
            prod_vld_reg  <= 1'b0;
            step_reg      <= '0;
        end else begin
            if (s_valid && s_ready) begin
                send_reg   <= s_send_time;
                server_reg <= s_server_time;
                recv_reg   <= s_receive_time;
            end
            if (state_reg == S_INSERT) begin
                if (len_reg != CNT_W'(WIN_SIZE)) begin
                    len_reg <= len_reg + 1'b1;
                end
                step_reg      <= '0;
                lsum_reg      <= '0;
                med_found_reg <= 1'b0;
            end
            if (state_reg == S_SUM) begin
                step_reg <= step_reg + 1'b1;
                if (tail.vld) begin
                    lsum_reg <= lsum_reg + LSUM_W'(tail_l16);
                    // median: element len/2 of the sorted window
                    if (lt_cnt <= (len_reg >> 1) && le_cnt > (len_reg >> 1)) begin
                        median_reg    <= tail.lat;
                        med_found_reg <= 1'b1;
                    end
                end
            end
            if (state_reg == S_MEAN_WAIT && !div_busy) begin
                mean_reg     <= div_quo[L16_W-1:0];
                step_reg     <= '0;
                var_reg      <= '0;
                prod_vld_reg <= 1'b0;
            end
            if (state_reg == S_VAR) begin
                step_reg     <= step_reg + 1'b1;
                prod_reg     <= SQ_W'(dabs) * SQ_W'(dabs);
                prod_vld_reg <= rotate && tail.vld;
                if (prod_vld_reg) begin
                    var_reg <= var_reg + VAR_W'(prod_reg);
                end
            end
            if (state_reg == S_SQRT_WAIT && !sqrt_busy) begin
                spread_reg <= sqrt_root;
                thr_reg    <= THR_W'({median_reg, 3'b000}) + THR_W'(sqrt_root);
                osum_reg   <= '0;
                qcnt_reg   <= '0;
                step_reg   <= '0;
            end
            if (state_reg == S_FILT) begin
                step_reg <= step_reg + 1'b1;
                if (tail.vld && THR_W'(tail_l16) < thr_reg) begin
                    osum_reg <= osum_reg + OSUM_W'(tail.ofs);
                    qcnt_reg <= qcnt_reg + 1'b1;
                end
            end
            if (state_reg == S_OFS_GO) begin
                neg_reg <= osum_reg[OSUM_W-1];
            end
            if (state_reg == S_OFS_WAIT && !div_busy) begin
                cur_ofs_reg <= neg_reg ? -signed'(div_quo[TIME_W-1:0])
                                       : signed'(div_quo[TIME_W-1:0]);
            end
            // send and receive times still hold this ping until the next accept
            if (out_load) begin
                m_valid_reg <= 1'b1;
                m_rt_reg    <= ping;
                m_med_reg   <= median_reg;
                m_spr_reg   <= SPREAD_W'(spread_reg);
                m_ofs_reg   <= cur_ofs_reg[COFS_W-1:0];
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_round_trip     = m_rt_reg;
    assign m_median_latency = m_med_reg;
    assign m_latency_spread = m_spr_reg;
    assign m_clock_offset   = signed'(m_ofs_reg);

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= CNT_W'(WIN_SIZE)) else $error("window length overflow");
    a_median_found: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MEAN_GO |-> med_found_reg) else $error("median not found");
    a_accept_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_INSERT) else $error("accept lost");
    a_window_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SUM |-> len_reg != '0) else $error("empty window in pass");

endmodule

### sv/pcof_cell.sv
// One window cell: holds a (latency, offset) pair and passes it down the chain.
// Depends on pcof_pkg.
module pcof_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       shift_en,
    input  pcof_pkg::entry_t           ent_in,
    input  logic [pcof_pkg::LAT_W-1:0] key,
    output pcof_pkg::entry_t           ent_out,
    output pcof_pkg::cmp_t             flags
);
    import pcof_pkg::*;

    entry_t ent_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.vld <= 1'b0;
        end else if (shift_en) begin
            ent_reg <= ent_in;
        end
    end

    assign ent_out  = ent_reg;
    assign flags.lt = ent_reg.vld && (ent_reg.lat < key);
    assign flags.le = ent_reg.vld && (ent_reg.lat <= key);

endmodule

### sv/pcof_div.sv
// Restoring divider, one quotient bit per cycle, small unsigned divisor.
// Depends on pcof_pkg.
module pcof_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [pcof_pkg::DIV_W-1:0] dividend,
    input  logic [pcof_pkg::CNT_W-1:0] divisor,
    output logic                       busy,
    output logic [pcof_pkg::DIV_W-1:0] quotient
);
    import pcof_pkg::*;

    logic [DIV_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   dvs_reg;
    logic [DSTEP_W-1:0] step_reg;
    logic               busy_reg;
    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     diff;
    logic               ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= DSTEP_W'(DIV_W);
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            quo_reg  <= {quo_reg[DIV_W-2:0], ge};
            rem_reg  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            step_reg <= step_reg - 1'b1;
            busy_reg <= (step_reg != DSTEP_W'(1));
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider restarted while busy");
    a_step_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> step_reg == '0) else $error("divider step count left over");
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && step_reg == DSTEP_W'(1) && !start |=> !busy_reg)
        else $error("divider overran");

endmodule

### sv/pcof_sqrt.sv
// Truncating integer square root, one result bit per cycle.
// Depends on pcof_pkg.
module pcof_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pcof_pkg::RAD_W-1:0]  radicand,
    output logic                        busy,
    output logic [pcof_pkg::ROOT_W-1:0] root
);
    import pcof_pkg::*;

    logic [RAD_W-1:0] v_reg;
    logic [RAD_W-1:0] res_reg;
    logic [RAD_W-1:0] bit_reg;
    logic             busy_reg;
    logic [RAD_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            v_reg    <= radicand;
            res_reg  <= '0;
            bit_reg  <= {2'b01, {(RAD_W-2){1'b0}}};
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg  <= bit_reg >> 2;
            busy_reg <= (bit_reg[RAD_W-1:2] != '0);
        end
    end

    assign busy = busy_reg;
    assign root = res_reg[ROOT_W-1:0];

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("sqrt restarted while busy");
    a_bit_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> $onehot(bit_reg)) else $error("sqrt bit lost");

endmodule

### tb/tb.sv
// Testbench for ping_clock_offset_filter_top: directed table, equal and random pings.
// Depends on pcof_pkg and the RTL top; predicts each result in a local model.
module tb;
    import pcof_pkg::*;

    localparam int NWIN = 16;
    localparam longint signed DLIM = 64'sd1 <<< 56;
    localparam longint signed OMAX = (64'sd1 <<< 57) - 1;
    localparam longint signed OMIN = -(64'sd1 <<< 57);

    typedef struct {
        logic [63:0] snd;
        logic [63:0] srv;
        logic [63:0] rcv;
    } ping_t;

    typedef struct {
        logic [15:0] rtt;
        logic [15:0] med;
        logic [19:0] spr;
        logic [62:0] ofs;
    } filt_res_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [63:0] s_send_time = 0, s_server_time = 0, s_receive_time = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [15:0] m_round_trip, m_median_latency;
    logic [19:0] m_latency_spread;
    logic signed [62:0] m_clock_offset;

    ping_clock_offset_filter_top dut (.*);

    initial forever #10 aclk = ~aclk;

    // predictor state
    logic [15:0] lat_win [NWIN];
    longint signed ofs_win [NWIN];
    int fill, oldest;
    longint signed cur_ofs;
    filt_res_t expected_q[$];
    int errors = 0;
    bit stim_done = 0;
    int out_wait = 0;

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic filt_res_t predict_filter(ping_t p);
        filt_res_t r;
        logic [15:0] rtt;
        longint signed diff, o, osum, q, rm;
        longint unsigned m, lsum, mean16, var_acc, spr, thr, l16, d;
        logic [15:0] srt [NWIN];
        int slot, n, j, cnt;
        rtt = 16'(p.rcv - p.snd);
        if (p.srv >= p.rcv) begin
            m = p.srv - p.rcv;
            diff = (m > DLIM) ? DLIM : longint'(m);
        end else begin
            m = p.rcv - p.srv;
            diff = (m > DLIM) ? -DLIM : -longint'(m);
        end
        o = 2 * diff + longint'(rtt);
        if (o > OMAX) o = OMAX;
        if (o < OMIN) o = OMIN;
        if (fill < NWIN) begin
            slot = (oldest + fill) % NWIN;
            fill++;
        end else begin
            slot = oldest;
            oldest = (oldest + 1) % NWIN;
        end
        lat_win[slot] = rtt;
        ofs_win[slot] = o;
        n = fill;
        for (int i = 0; i < n; i++) begin
            j = i;
            while (j > 0 && srt[j-1] > lat_win[i]) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = lat_win[i];
        end
        lsum = 0;
        for (int i = 0; i < n; i++) lsum += longint'(lat_win[i]) * 8;
        mean16 = lsum / n;
        var_acc = 0;
        for (int i = 0; i < n; i++) begin
            l16 = longint'(lat_win[i]) * 8;
            d = (l16 >= mean16) ? l16 - mean16 : mean16 - l16;
            var_acc += d * d;
        end
        var_acc /= n;
        spr = root64(var_acc);
        thr = longint'(srt[n/2]) * 8 + spr;
        osum = 0;
        cnt = 0;
        for (int i = 0; i < n; i++)
            if (longint'(lat_win[i]) * 8 < thr) begin
                osum += ofs_win[i];
                cnt++;
            end
        if (cnt > 0) begin
            q = osum / cnt;
            rm = osum % cnt;
            cur_ofs = q * 8 + (rm * 8) / cnt;
        end
        r.rtt = rtt;
        r.med = srt[n/2];
        r.spr = spr[19:0];
        r.ofs = cur_ofs[62:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("error: %s got %0h want %0h", what, got, want);
        errors++;
    endtask

    // hold valid between back-to-back transfers; drop it only for an idle gap
    task automatic send_ping(ping_t p);
        int gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_send_time <= p.snd;
        s_server_time <= p.srv;
        s_receive_time <= p.rcv;
        do @(posedge aclk); while (!s_ready);
        expected_q.insert(expected_q.size(), predict_filter(p));
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic ping_t rand_ping();
        ping_t p;
        logic [63:0] base = rnd64();
        int k = $urandom_range(0, 9);
        p.snd = base;
        p.rcv = base + $urandom_range(0, (k < 5) ? 40 : 70000);
        p.srv = p.rcv + 64'($signed($urandom_range(0, 20000)) - 10000);
        if (k == 8) p.srv = rnd64();
        if (k == 9) begin
            p.snd = rnd64();
            p.rcv = rnd64();
        end
        return p;
    endfunction

    // directed table: send, server, receive
    initial begin
        ping_t p;
        ping_t t [] = '{
            '{64'd0, 64'd0, 64'd0},
            '{64'd100, 64'd5000, 64'd110},
            '{'1, '1, '1},
            '{64'd5, '1, 64'd0},
            '{64'd0, 64'd0, '1},
            '{'1, 64'd0, 64'd0},
            '{64'd0, 64'h8000_0000_0000_0000, 64'd65535},
            '{64'd10, 64'd20, 64'd30},
            '{64'd10, 64'd20, 64'd30},
            '{64'd10, 64'd20, 64'd30},
            '{64'd0, 64'd1000, 64'd1},
            '{64'd0, 64'd3, 64'd900},
            '{64'h0100_0000_0000_0000, 64'd0, 64'h0100_0000_0000_0010},
            '{64'd0, 64'h0200_0000_0000_0000, 64'd2},
            '{64'hFFFF_FFFF_FFFF_0000, 64'd7, 64'd16},
            '{64'd1, 64'd1, 64'd1},
            '{64'd2, 64'd50, 64'd4},
            '{64'd0, 64'h5555_5555_5555_5555, 64'hAAAA},
            '{64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
            '{64'd0, 64'd0, 64'd0}
        };
        fill = 0;
        oldest = 0;
        cur_ofs = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (t[i]) send_ping(t[i]);
        // all-equal latencies keep the previous offset
        repeat (18) begin
            p = '{64'd7, 64'd7, 64'd9};
            send_ping(p);
        end
        repeat (850) send_ping(rand_ping());
        s_valid <= 0;
        stim_done = 1;
    end

    // first result after reset, read off at a glance: all zero
    bit first = 1;
    always @(posedge aclk) begin
        filt_res_t e;
        if (!aresetn) begin
            m_ready <= 0;
            out_wait = $urandom_range(0, 6);
        end else if (m_valid && m_ready) begin
            m_ready <= 0;
            out_wait = $urandom_range(0, 6);
            if (expected_q.size() == 0) report_mismatch("unexpected result", 0, 0);
            else begin
                e = expected_q[0];
                expected_q.delete(0);
                if (first && (m_round_trip !== 16'd0 || m_median_latency !== 16'd0 ||
                              m_latency_spread !== 20'd0 || m_clock_offset !== 63'd0))
                    report_mismatch("reset result", 1, 0);
                first = 0;
                if (m_round_trip !== e.rtt) report_mismatch("round_trip", m_round_trip, e.rtt);
                if (m_median_latency !== e.med)
                    report_mismatch("median_latency", m_median_latency, e.med);
                if (m_latency_spread !== e.spr)
                    report_mismatch("latency_spread", m_latency_spread, e.spr);
                if (m_clock_offset !== e.ofs)
                    report_mismatch("clock_offset", m_clock_offset, e.ofs);
            end
        end else if (m_valid) begin
            if (out_wait == 0) m_ready <= 1;
            else out_wait--;
        end
    end

    initial begin
        wait (stim_done);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #(20 * 2000000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
